@@ hdl/tra_pkg.sv @@
// tra_pkg: word types, field widths and fixed-point constants for the tanh pipeline.
// No dependencies; imported by every tra_* module and by tanh_rational_approx.
`default_nettype none

package tra_pkg;

    // input and output words
    typedef struct packed {
        logic signed [15:0] x_in;
        logic               last_in;
    } t_tanh_in;

    typedef struct packed {
        logic signed [15:0] y_out;
        logic               last_out;
    } t_tanh_out;

    // flags that travel beside the arithmetic
    typedef struct packed {
        logic last;
        logic neg;
        logic sat;
    } t_side;

    // widths of the intermediate values (bounded by |x| <= 5.0)
    localparam int W_X   = 16;
    localparam int W_A   = 14;
    localparam int W_S   = 27;
    localparam int W_P1  = 27;
    localparam int W_Q1  = 30;
    localparam int W_P2  = 33;
    localparam int W_Q2  = 36;
    localparam int W_P3  = 38;
    localparam int W_Q3  = 40;
    localparam int W_NUM = W_P3 + W_A;
    localparam int W_DEN = W_Q3 + 1;
    localparam int W_REM = W_NUM + 5;
    localparam int W_QUO = 16;

    localparam logic signed [W_X-1:0] LIMIT_POS = 16'sd10240;
    localparam logic signed [W_X-1:0] LIMIT_NEG = -16'sd10240;
    localparam logic [W_QUO-1:0]      ONE_Q14   = 16'd16384;

    // Horner constants in Q18
    localparam logic [W_P1-1:0] K_P1 = W_P1'(64'd378 << 18);
    localparam logic [W_P2-1:0] K_P2 = W_P2'(64'd17325 << 18);
    localparam logic [W_P3-1:0] K_P3 = W_P3'(64'd135135 << 18);
    localparam logic [W_Q1-1:0] K_Q1 = W_Q1'(64'd3150 << 18);
    localparam logic [W_Q2-1:0] K_Q2 = W_Q2'(64'd62370 << 18);
    localparam logic [W_Q3-1:0] K_Q3 = W_Q3'(64'd135135 << 18);

    // rounding offsets for the shifts by 4 and by 22
    localparam logic [63:0] HALF_4  = 64'd8;
    localparam logic [63:0] HALF_22 = 64'd2097152;

endpackage

`default_nettype wire

@@ hdl/tra_poly.sv @@
// tra_poly: magnitude, square and Horner evaluation of numerator and denominator.
// Eight register stages; depends on tra_pkg.
`default_nettype none

module tra_poly
    import tra_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_tanh_in         i_word,
    output logic                  o_valid,
    output logic [W_NUM-1:0]      o_num,
    output logic [W_Q3-1:0]       o_q3,
    output t_side                 o_side
);

    localparam int W_MP1 = W_P1 + W_S;
    localparam int W_MQ1 = W_Q1 + W_S;
    localparam int W_MP2 = W_P2 + W_S;
    localparam int W_MQ2 = W_Q2 + W_S;

    logic [8:1] r_v;

    // stage 1: sign, saturation, magnitude
    logic          n1_neg;
    logic          n1_sat;
    logic [W_X-1:0] n1_abs;
    logic [W_A-1:0] n1_a;
    t_side          r1_side;
    logic [W_A-1:0] r1_a;

    assign n1_neg = i_word.x_in[W_X-1];
    assign n1_sat = (i_word.x_in > LIMIT_POS) || (i_word.x_in < LIMIT_NEG);
    assign n1_abs = n1_neg ? W_X'(-i_word.x_in) : W_X'(i_word.x_in);
    assign n1_a   = n1_sat ? '0 : n1_abs[W_A-1:0];

    // stage 2: square
    logic [2*W_A-1:0] n2_sq;
    t_side            r2_side;
    logic [W_A-1:0]   r2_a;
    logic [W_S-1:0]   r2_s;

    assign n2_sq = r1_a * r1_a;

    // stage 3: first Horner step
    logic [W_S:0]    n3_tp;
    logic [W_S+4:0]  n3_s28;
    logic [W_S+5:0]  n3_tq;
    logic [W_P1-1:0] n3_p1;
    logic [W_Q1-1:0] n3_q1;
    t_side           r3_side;
    logic [W_A-1:0]  r3_a;
    logic [W_S-1:0]  r3_s;
    logic [W_P1-1:0] r3_p1;
    logic [W_Q1-1:0] r3_q1;

    assign n3_tp  = {1'b0, r2_s} + (W_S+1)'(HALF_4);
    assign n3_s28 = {r2_s, 5'b0} - {2'b0, r2_s, 2'b0};
    assign n3_tq  = {1'b0, n3_s28} + (W_S+6)'(HALF_4);
    assign n3_p1  = W_P1'(n3_tp[W_S:4]) + K_P1;
    assign n3_q1  = W_Q1'(n3_tq[W_S+5:4]) + K_Q1;

    // stage 4: products p1*s, q1*s
    t_side            r4_side;
    logic [W_A-1:0]   r4_a;
    logic [W_S-1:0]   r4_s;
    logic [W_MP1-1:0] r4_mp;
    logic [W_MQ1-1:0] r4_mq;

    // stage 5: round and add
    logic [W_MP1:0]  n5_tp;
    logic [W_MQ1:0]  n5_tq;
    t_side           r5_side;
    logic [W_A-1:0]  r5_a;
    logic [W_S-1:0]  r5_s;
    logic [W_P2-1:0] r5_p2;
    logic [W_Q2-1:0] r5_q2;

    assign n5_tp = {1'b0, r4_mp} + (W_MP1+1)'(HALF_22);
    assign n5_tq = {1'b0, r4_mq} + (W_MQ1+1)'(HALF_22);

    // stage 6: products p2*s, q2*s
    t_side            r6_side;
    logic [W_A-1:0]   r6_a;
    logic [W_MP2-1:0] r6_mp;
    logic [W_MQ2-1:0] r6_mq;

    // stage 7: round and add
    logic [W_MP2:0]  n7_tp;
    logic [W_MQ2:0]  n7_tq;
    t_side           r7_side;
    logic [W_A-1:0]  r7_a;
    logic [W_P3-1:0] r7_p3;
    logic [W_Q3-1:0] r7_q3;

    assign n7_tp = {1'b0, r6_mp} + (W_MP2+1)'(HALF_22);
    assign n7_tq = {1'b0, r6_mq} + (W_MQ2+1)'(HALF_22);

    // stage 8: numerator p3*a
    t_side            r8_side;
    logic [W_NUM-1:0] r8_num;
    logic [W_Q3-1:0]  r8_q3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= '{last: i_word.last_in, neg: n1_neg, sat: n1_sat};
            r1_a    <= n1_a;

            r2_side <= r1_side;
            r2_a    <= r1_a;
            r2_s    <= n2_sq[W_S-1:0];

            r3_side <= r2_side;
            r3_a    <= r2_a;
            r3_s    <= r2_s;
            r3_p1   <= n3_p1;
            r3_q1   <= n3_q1;

            r4_side <= r3_side;
            r4_a    <= r3_a;
            r4_s    <= r3_s;
            r4_mp   <= r3_p1 * r3_s;
            r4_mq   <= r3_q1 * r3_s;

            r5_side <= r4_side;
            r5_a    <= r4_a;
            r5_s    <= r4_s;
            r5_p2   <= n5_tp[W_P2+21:22] + K_P2;
            r5_q2   <= n5_tq[W_Q2+21:22] + K_Q2;

            r6_side <= r5_side;
            r6_a    <= r5_a;
            r6_mp   <= r5_p2 * r5_s;
            r6_mq   <= r5_q2 * r5_s;

            r7_side <= r6_side;
            r7_a    <= r6_a;
            r7_p3   <= n7_tp[W_P3+21:22] + K_P3;
            r7_q3   <= n7_tq[W_Q3+21:22] + K_Q3;

            r8_side <= r7_side;
            r8_num  <= r7_p3 * r7_a;
            r8_q3   <= r7_q3;
        end
    end

    assign o_valid = r_v[8];
    assign o_num   = r8_num;
    assign o_q3    = r8_q3;
    assign o_side  = r8_side;

endmodule

`default_nettype wire

@@ hdl/tra_div.sv @@
// tra_div: pipelined restoring divider, one quotient bit per stage, round half up.
// Computes (16*num + q3) / (2*q3); depends on tra_pkg.
`default_nettype none

module tra_div
    import tra_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [W_NUM-1:0] i_num,
    input  wire logic [W_Q3-1:0]  i_q3,
    input  wire t_side            i_side,
    output logic                  o_valid,
    output logic [W_QUO-1:0]      o_quo,
    output t_side                 o_side
);

    logic [W_REM-1:0] r_rem  [0:W_QUO];
    logic [W_DEN-1:0] r_den  [0:W_QUO];
    logic [W_QUO-1:0] r_quo  [0:W_QUO];
    t_side            r_side [0:W_QUO];
    logic [W_QUO:0]   r_v;

    // entry stage: rounding folded into dividend and divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= W_REM'({i_num, 4'b0}) + W_REM'(i_q3);
            r_den[0]  <= {i_q3, 1'b0};
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    genvar g;
    generate
        for (g = 0; g < W_QUO; g++) begin : g_stage
            logic [W_REM-1:0] n_shd;
            logic [W_REM:0]   n_diff;
            logic             n_ge;

            // trial subtract of den shifted to this stage's quotient bit
            assign n_shd  = W_REM'(r_den[g]) << (W_QUO - 1 - g);
            assign n_diff = {1'b0, r_rem[g]} - {1'b0, n_shd};
            assign n_ge   = !n_diff[W_REM];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[g+1] <= r_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g+1]  <= n_ge ? n_diff[W_REM-1:0] : r_rem[g];
                    r_den[g+1]  <= r_den[g];
                    r_quo[g+1]  <= {r_quo[g][W_QUO-2:0], n_ge};
                    r_side[g+1] <= r_side[g];
                end
            end
        end
    endgenerate

    assign o_valid = r_v[W_QUO];
    assign o_quo   = r_quo[W_QUO];
    assign o_side  = r_side[W_QUO];

endmodule

`default_nettype wire

@@ hdl/tra_out.sv @@
// tra_out: saturation and sign, output register and skid word.
// Drives the pipeline enable; depends on tra_pkg.
`default_nettype none

module tra_out
    import tra_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [W_QUO-1:0] i_quo,
    input  wire t_side            i_side,
    output logic                  o_en,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_tanh_out             o_word
);

    logic [W_QUO-1:0] n_mag;
    t_tanh_out        n_word;
    t_tanh_out        r_out;
    t_tanh_out        r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;

    assign n_mag = (i_side.sat || (i_quo > ONE_Q14)) ? ONE_Q14 : i_quo;
    assign n_word.y_out    = i_side.neg ? -$signed(n_mag) : $signed(n_mag);
    assign n_word.last_out = i_side.last;

    // pipeline moves only while the skid word is free
    assign o_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= i_valid;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || i_ready) begin
            r_out <= n_word;
        end else begin
            r_skid <= n_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

`default_nettype wire

@@ hdl/tanh_rational_approx.sv @@
// tanh_rational_approx: top level of the streaming tanh unit.
// Instantiates tra_poly, tra_div and tra_out; depends on tra_pkg.
//
// Takes one Q4.11 word per clock and returns tanh as a Q1.14 word, rounded
// to nearest with ties away from zero, saturating to +/-1.0 beyond |x| = 5.0.
// The last flag rides along unchanged. Throughput is one word per cycle
// while the skid word is free. A word passes through 8 stages of squaring
// and Horner evaluation (products in stages 2, 4, 6 and 8), 17 stages of
// the bit-per-stage divider, and the output register. A full skid word holds
// the whole pipeline; o_ready comes straight from a register.
`default_nettype none

module tanh_rational_approx
    import tra_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_tanh_in  i_word,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_tanh_out      o_word
);

    logic             en;
    logic             poly_valid;
    logic [W_NUM-1:0] poly_num;
    logic [W_Q3-1:0]  poly_q3;
    t_side            poly_side;
    logic             div_valid;
    logic [W_QUO-1:0] div_quo;
    t_side            div_side;

    tra_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_valid (poly_valid),
        .o_num   (poly_num),
        .o_q3    (poly_q3),
        .o_side  (poly_side)
    );

    tra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (poly_valid),
        .i_num   (poly_num),
        .i_q3    (poly_q3),
        .i_side  (poly_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    tra_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_quo   (div_quo),
        .i_side  (div_side),
        .o_en    (en),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    assign o_ready = en;

endmodule

`default_nettype wire
